FILE: design/lrt_pkg.sv
package lrt_pkg;

    // Array size and derived widths.
    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = $clog2(MAX_POSITIONS);
    localparam int LEN_W         = POS_W + 1;
    localparam int NODE_W        = POS_W + 1;
    localparam int NODE_SLOTS    = 2 * MAX_POSITIONS;
    localparam int DATA_W        = 32;
    localparam int STK_DEPTH     = POS_W;
    localparam int SP_W          = $clog2(STK_DEPTH + 1);
    localparam int TYPE_W        = 2;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_MAX    = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SEARCH = 2'd2;

    // Register index of the length register.
    localparam logic REG_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT,
        S_NODE,
        S_PDL,
        S_PDR,
        S_RET,
        S_PU0,
        S_PU1,
        S_PU2,
        S_SRCH,
        S_SCMP,
        S_DONE
    } t_state;

    // One saved parent frame of the tree walk.
    typedef struct packed {
        logic [NODE_W-1:0]        node;
        logic [POS_W-1:0]         lo;
        logic [POS_W-1:0]         hi;
        logic                     phase;
        logic signed [DATA_W-1:0] left;
    } t_frame;

    function automatic logic signed [DATA_W-1:0] f_smax(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

FILE: design/lrt_if.sv
interface lrt_req_if;
    logic                             valid;
    logic                             ready;
    logic [lrt_pkg::TYPE_W-1:0]       req_type;
    logic [lrt_pkg::POS_W-1:0]        range_low;
    logic [lrt_pkg::POS_W-1:0]        range_high;
    logic signed [lrt_pkg::DATA_W-1:0] amount;

    modport source (output valid, req_type, range_low, range_high, amount, input ready);
    modport sink (input valid, req_type, range_low, range_high, amount, output ready);
endinterface

interface lrt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [lrt_pkg::DATA_W-1:0] range_max;
    logic [lrt_pkg::POS_W-1:0]         found_position;

    modport source (output valid, range_max, found_position, input ready);
    modport sink (input valid, range_max, found_position, output ready);
endinterface

FILE: design/lazy_range_add_max_tree.sv
// Channel   Role     Payload
// i_req     sink     req_type, range_low, range_high, amount
// o_rsp     source   range_max, found_position
// APB       slave    active_length at byte address 0
//
// One transaction at a time; node values live in two 2048-entry RAMs.
// Add/query: a partially covered node is visited, pushed down, then updated from its children on return.
// Search: descends one tree level per SRCH, NODE, PDL, PDR, SCMP pass.
// Reset and every length write start a clearing pass over all 2048 node entries; no requests then.
// A finished result waits in an output register while the next request starts.
module lazy_range_add_max_tree (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lrt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lrt_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    lrt_req_if.sink                        i_req,
    lrt_rsp_if.source                      o_rsp
);

    logic [lrt_pkg::LEN_W-1:0] r_len, wr_len;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == lrt_pkg::REG_LENGTH);

    // Clamp the written length to 1..MAX_POSITIONS.
    always_comb begin
        wr_len = pwdata[lrt_pkg::LEN_W-1:0];
        if (wr_len == '0) wr_len = lrt_pkg::LEN_W'(1);
        else if (wr_len > lrt_pkg::LEN_W'(lrt_pkg::MAX_POSITIONS)) begin
            wr_len = lrt_pkg::LEN_W'(lrt_pkg::MAX_POSITIONS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= lrt_pkg::LEN_W'(lrt_pkg::MAX_POSITIONS);
        end else if (wr_en) begin
            r_len <= wr_len;
        end
    end

    assign prdata = (paddr[2] == lrt_pkg::REG_LENGTH)
                    ? {{(lrt_pkg::APB_DATA_W-lrt_pkg::LEN_W){1'b0}}, r_len} : '0;

    lrt_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (wr_en),
        .i_len   (r_len),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: design/lrt_ram.sv
module lrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lrt_engine.sv
module lrt_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic [lrt_pkg::LEN_W-1:0] i_len,
    lrt_req_if.sink                   i_req,
    lrt_rsp_if.source                 o_rsp
);

    lrt_pkg::t_state r_state, n_state;

    logic [lrt_pkg::TYPE_W-1:0]        r_op;
    logic [lrt_pkg::POS_W-1:0]         r_a, r_b, r_lo, r_hi, r_found;
    logic signed [lrt_pkg::DATA_W-1:0] r_v, r_ret, r_left, r_fl, r_d;
    logic [lrt_pkg::NODE_W-1:0]        r_node, r_clr;
    logic [lrt_pkg::SP_W-1:0]          r_sp;
    lrt_pkg::t_frame                   r_stk [lrt_pkg::STK_DEPTH];

    logic                              r_ov;
    logic signed [lrt_pkg::DATA_W-1:0] r_omax;
    logic [lrt_pkg::POS_W-1:0]         r_opos;

    // Memory port controls.
    logic                              max_we, pend_we;
    logic [lrt_pkg::NODE_W-1:0]        max_wa, pend_wa, max_ra, pend_ra;
    logic signed [lrt_pkg::DATA_W-1:0] max_wd, pend_wd, max_rd, pend_rd;

    // Stack write port.
    logic                              stk_we;
    logic [lrt_pkg::SP_W-1:0]          stk_idx;
    lrt_pkg::t_frame                   stk_wd, pop;
    logic [lrt_pkg::SP_W-1:0]          sp_m1;

    logic [lrt_pkg::POS_W:0]           sum, pop_sum;
    logic [lrt_pkg::POS_W-1:0]         mid, pop_mid, top;
    logic [lrt_pkg::NODE_W-1:0]        lchild, rchild;
    logic                              covered, disjoint, accept, out_free;
    logic signed [lrt_pkg::DATA_W-1:0] full;

    lrt_ram #(.WIDTH(lrt_pkg::DATA_W), .DEPTH(lrt_pkg::NODE_SLOTS)) u_max (
        .i_clk   (i_clk),
        .i_we    (max_we),
        .i_waddr (max_wa),
        .i_wdata (max_wd),
        .i_raddr (max_ra),
        .o_rdata (max_rd)
    );

    lrt_ram #(.WIDTH(lrt_pkg::DATA_W), .DEPTH(lrt_pkg::NODE_SLOTS)) u_pend (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_wa),
        .i_wdata (pend_wd),
        .i_raddr (pend_ra),
        .o_rdata (pend_rd)
    );

    // Node geometry of the current frame and of the frame on top of the stack.
    assign sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = sum[lrt_pkg::POS_W:1];
    assign lchild   = {r_node[lrt_pkg::NODE_W-2:0], 1'b0};
    assign rchild   = {r_node[lrt_pkg::NODE_W-2:0], 1'b1};
    assign sp_m1    = r_sp - lrt_pkg::SP_W'(1);
    assign pop      = r_stk[sp_m1];
    assign pop_sum  = {1'b0, pop.lo} + {1'b0, pop.hi};
    assign pop_mid  = pop_sum[lrt_pkg::POS_W:1];
    assign covered  = (r_a <= r_lo) && (r_hi <= r_b);
    assign disjoint = (r_hi < r_a) || (r_lo > r_b);
    assign full     = max_rd + pend_rd;
    assign top      = lrt_pkg::POS_W'(i_len - lrt_pkg::LEN_W'(1));

    assign i_req.ready = (r_state == lrt_pkg::S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_ov || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lrt_pkg::S_CLEAR: begin
                if (r_clr == {lrt_pkg::NODE_W{1'b1}}) n_state = lrt_pkg::S_IDLE;
            end
            lrt_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        lrt_pkg::REQ_ADD, lrt_pkg::REQ_MAX: n_state = lrt_pkg::S_VISIT;
                        lrt_pkg::REQ_SEARCH: n_state = lrt_pkg::S_SRCH;
                        default: n_state = lrt_pkg::S_DONE;
                    endcase
                end
            end
            lrt_pkg::S_VISIT: n_state = disjoint ? lrt_pkg::S_RET : lrt_pkg::S_NODE;
            lrt_pkg::S_NODE: begin
                n_state = (r_op != lrt_pkg::REQ_SEARCH && covered) ? lrt_pkg::S_RET
                                                                    : lrt_pkg::S_PDL;
            end
            lrt_pkg::S_PDL: n_state = lrt_pkg::S_PDR;
            lrt_pkg::S_PDR: begin
                n_state = (r_op == lrt_pkg::REQ_SEARCH) ? lrt_pkg::S_SCMP : lrt_pkg::S_VISIT;
            end
            lrt_pkg::S_RET: begin
                if (r_sp == '0) n_state = lrt_pkg::S_DONE;
                else if (!pop.phase) n_state = lrt_pkg::S_VISIT;
                else n_state = lrt_pkg::S_PU0;
            end
            lrt_pkg::S_PU0: n_state = lrt_pkg::S_PU1;
            lrt_pkg::S_PU1: n_state = lrt_pkg::S_PU2;
            lrt_pkg::S_PU2: n_state = lrt_pkg::S_RET;
            lrt_pkg::S_SRCH: n_state = (r_lo < r_hi) ? lrt_pkg::S_NODE : lrt_pkg::S_DONE;
            lrt_pkg::S_SCMP: n_state = lrt_pkg::S_SRCH;
            lrt_pkg::S_DONE: begin
                if (out_free) n_state = lrt_pkg::S_IDLE;
            end
            default: n_state = lrt_pkg::S_IDLE;
        endcase
        if (i_clear) n_state = lrt_pkg::S_CLEAR;
    end

    // Memory and stack controls.
    always_comb begin
        max_we  = 1'b0;
        pend_we = 1'b0;
        max_wa  = r_node;
        pend_wa = r_node;
        max_wd  = '0;
        pend_wd = '0;
        max_ra  = r_node;
        pend_ra = r_node;
        stk_we  = 1'b0;
        stk_idx = r_sp;
        stk_wd  = '{node: r_node, lo: r_lo, hi: r_hi, phase: 1'b0, left: '0};
        case (r_state)
            lrt_pkg::S_CLEAR: begin
                max_we  = 1'b1;
                pend_we = 1'b1;
                max_wa  = r_clr;
                pend_wa = r_clr;
            end
            lrt_pkg::S_NODE: begin
                if (r_op != lrt_pkg::REQ_SEARCH && covered) begin
                    if (r_op == lrt_pkg::REQ_ADD) begin
                        pend_we = 1'b1;
                        pend_wd = pend_rd + r_v;
                    end
                end else begin
                    // Push the pending add down into the node and its children.
                    max_we  = 1'b1;
                    max_wd  = full;
                    pend_we = 1'b1;
                    pend_ra = lchild;
                end
            end
            lrt_pkg::S_PDL: begin
                pend_we = 1'b1;
                pend_wa = lchild;
                pend_wd = pend_rd + r_d;
                pend_ra = rchild;
            end
            lrt_pkg::S_PDR: begin
                pend_we = 1'b1;
                pend_wa = rchild;
                pend_wd = pend_rd + r_d;
                max_ra  = lchild;
                pend_ra = lchild;
                stk_we  = (r_op != lrt_pkg::REQ_SEARCH);
            end
            lrt_pkg::S_RET: begin
                // Going to the right child: mark the parent and keep the left result.
                if (r_sp != '0 && !pop.phase) begin
                    stk_we  = 1'b1;
                    stk_idx = sp_m1;
                    stk_wd  = '{node: pop.node, lo: pop.lo, hi: pop.hi, phase: 1'b1,
                                left: r_ret};
                end
            end
            lrt_pkg::S_PU0: begin
                max_ra  = lchild;
                pend_ra = lchild;
            end
            lrt_pkg::S_PU1: begin
                max_ra  = rchild;
                pend_ra = rchild;
            end
            lrt_pkg::S_PU2: begin
                max_we = 1'b1;
                max_wd = lrt_pkg::f_smax(r_fl, full);
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrt_pkg::S_CLEAR;
            r_clr   <= '0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_clear) r_clr <= '0;
            else if (r_state == lrt_pkg::S_CLEAR) r_clr <= r_clr + lrt_pkg::NODE_W'(1);
            if (accept) r_sp <= '0;
            else if (r_state == lrt_pkg::S_PDR && r_op != lrt_pkg::REQ_SEARCH) begin
                r_sp <= r_sp + lrt_pkg::SP_W'(1);
            end else if (r_state == lrt_pkg::S_RET && r_sp != '0 && pop.phase) begin
                r_sp <= sp_m1;
            end
            if (r_state == lrt_pkg::S_DONE && out_free) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk[stk_idx] <= stk_wd;
        case (r_state)
            lrt_pkg::S_IDLE: begin
                r_op    <= i_req.req_type;
                r_a     <= i_req.range_low;
                r_b     <= i_req.range_high;
                r_v     <= i_req.amount;
                r_node  <= lrt_pkg::NODE_W'(1);
                r_lo    <= '0;
                r_hi    <= top;
                r_ret   <= '0;
                r_found <= '0;
            end
            lrt_pkg::S_VISIT: begin
                if (disjoint) r_ret <= lrt_pkg::MOST_NEG;
            end
            lrt_pkg::S_NODE: begin
                if (r_op != lrt_pkg::REQ_SEARCH && covered) r_ret <= full;
                else r_d <= pend_rd;
            end
            lrt_pkg::S_PDR: begin
                if (r_op != lrt_pkg::REQ_SEARCH) begin
                    r_node <= lchild;
                    r_hi   <= mid;
                end
            end
            lrt_pkg::S_RET: begin
                if (r_sp != '0) begin
                    if (!pop.phase) begin
                        r_node <= {pop.node[lrt_pkg::NODE_W-2:0], 1'b1};
                        r_lo   <= pop_mid + lrt_pkg::POS_W'(1);
                        r_hi   <= pop.hi;
                    end else begin
                        r_node <= pop.node;
                        r_lo   <= pop.lo;
                        r_hi   <= pop.hi;
                        r_left <= pop.left;
                    end
                end
            end
            lrt_pkg::S_PU1: r_fl <= full;
            lrt_pkg::S_PU2: r_ret <= lrt_pkg::f_smax(r_left, r_ret);
            lrt_pkg::S_SRCH: begin
                if (!(r_lo < r_hi)) r_found <= r_lo;
            end
            lrt_pkg::S_SCMP: begin
                if (full >= r_v) begin
                    r_node <= lchild;
                    r_hi   <= mid;
                end else begin
                    r_node <= rchild;
                    r_lo   <= mid + lrt_pkg::POS_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == lrt_pkg::S_DONE && out_free) begin
            r_omax <= (r_op == lrt_pkg::REQ_MAX) ? r_ret : '0;
            r_opos <= (r_op == lrt_pkg::REQ_SEARCH) ? r_found : '0;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.range_max      = r_omax;
    assign o_rsp.found_position = r_opos;

`ifndef NO_ASSERTIONS
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrt_pkg::S_PDR && r_op != lrt_pkg::REQ_SEARCH)
            |-> (r_sp < lrt_pkg::SP_W'(lrt_pkg::STK_DEPTH)))
        else $error("tree walk stack overflow");
    a_node_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrt_pkg::S_VISIT) |-> (r_lo <= r_hi && r_node != '0))
        else $error("visited node has an empty span");
    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_state == lrt_pkg::S_CLEAR && r_clr == '0))
        else $error("length write did not start a clearing pass");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrt_pkg::S_RET && r_sp == '0) |=> (r_state == lrt_pkg::S_DONE
            || r_state == lrt_pkg::S_CLEAR))
        else $error("root return did not finish the transaction");
`endif

endmodule

FILE: test/tb_lazy_range_add_max_tree.sv
`timescale 1ns / 1ps

module tb_lazy_range_add_max_tree;

    localparam int        CLK_HALF    = 6;
    localparam int        CYCLE_LIMIT = 2_000_000;
    localparam int        TREE_SLOTS  = 4 * lrt_pkg::MAX_POSITIONS;
    localparam int        HOLD_CYCLES = 400;
    localparam logic [lrt_pkg::TYPE_W-1:0]     REQ_UNUSED  = 2'd3;
    localparam logic [lrt_pkg::APB_ADDR_W-1:0] ADDR_LENGTH = 3'd0;
    localparam logic [lrt_pkg::APB_ADDR_W-1:0] ADDR_NONE   = 3'd4;

    typedef struct packed {
        logic [lrt_pkg::DATA_W-1:0] range_max;
        logic [lrt_pkg::POS_W-1:0]  found_position;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [lrt_pkg::APB_ADDR_W-1:0] paddr;
    logic [lrt_pkg::APB_DATA_W-1:0] pwdata, prdata;

    lrt_req_if req_ch ();
    lrt_rsp_if rsp_ch ();

    lazy_range_add_max_tree DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow copy of the tree and of the length register.
    logic [lrt_pkg::DATA_W-1:0] shadow_max [TREE_SLOTS];
    logic [lrt_pkg::DATA_W-1:0] shadow_pend[TREE_SLOTS];
    int unsigned                shadow_len;

    t_answer answer_q[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lazy_range_add_max_tree regression: fail");
            $finish;
        end
    end

    function automatic bit sgeq(logic [lrt_pkg::DATA_W-1:0] a,
                                logic [lrt_pkg::DATA_W-1:0] b);
        return $signed(a) >= $signed(b);
    endfunction

    function automatic logic [lrt_pkg::DATA_W-1:0] node_total(int node);
        if (node >= TREE_SLOTS) return lrt_pkg::MOST_NEG;
        return shadow_max[node] + shadow_pend[node];
    endfunction

    function automatic void push_pending(int node);
        logic [lrt_pkg::DATA_W-1:0] d;
        if (2 * node + 1 >= TREE_SLOTS) return;
        d = shadow_pend[node];
        shadow_pend[2 * node]     += d;
        shadow_pend[2 * node + 1] += d;
        shadow_max[node]          += d;
        shadow_pend[node]          = 0;
    endfunction

    function automatic void refresh_node(int node);
        logic [lrt_pkg::DATA_W-1:0] l, r;
        if (2 * node + 1 >= TREE_SLOTS) return;
        l = node_total(2 * node);
        r = node_total(2 * node + 1);
        shadow_max[node] = sgeq(l, r) ? l : r;
    endfunction

    function automatic void tree_add(int node, int lo, int hi, int a, int b,
                                     logic [lrt_pkg::DATA_W-1:0] v);
        int mid;
        if (node >= TREE_SLOTS || hi < a || lo > b) return;
        if (a <= lo && hi <= b) begin
            shadow_pend[node] += v;
            return;
        end
        push_pending(node);
        mid = (lo + hi) >> 1;
        tree_add(2 * node, lo, mid, a, b, v);
        tree_add(2 * node + 1, mid + 1, hi, a, b, v);
        refresh_node(node);
    endfunction

    function automatic logic [lrt_pkg::DATA_W-1:0] tree_max(int node, int lo, int hi,
                                                            int a, int b);
        int mid;
        logic [lrt_pkg::DATA_W-1:0] l, r;
        if (node >= TREE_SLOTS || hi < a || lo > b) return lrt_pkg::MOST_NEG;
        if (a <= lo && hi <= b) return node_total(node);
        push_pending(node);
        mid = (lo + hi) >> 1;
        l = tree_max(2 * node, lo, mid, a, b);
        r = tree_max(2 * node + 1, mid + 1, hi, a, b);
        refresh_node(node);
        return sgeq(l, r) ? l : r;
    endfunction

    function automatic int leftmost_at_least(logic [lrt_pkg::DATA_W-1:0] threshold);
        int node, lo, hi, mid;
        node = 1;
        lo = 0;
        hi = shadow_len - 1;
        while (lo < hi && 2 * node + 1 < TREE_SLOTS) begin
            push_pending(node);
            mid = (lo + hi) >> 1;
            if (sgeq(node_total(2 * node), threshold)) begin
                node = 2 * node;
                hi = mid;
            end else begin
                node = 2 * node + 1;
                lo = mid + 1;
            end
        end
        return lo;
    endfunction

    function automatic void clear_shadow();
        foreach (shadow_max[i]) begin
            shadow_max[i]  = 0;
            shadow_pend[i] = 0;
        end
    endfunction

    // Expected answer for one accepted request; updates the shadow tree.
    function automatic t_answer predict_answer(logic [lrt_pkg::TYPE_W-1:0] kind,
                                               int a, int b,
                                               logic [lrt_pkg::DATA_W-1:0] amt);
        t_answer ans;
        ans = '0;
        case (kind)
            lrt_pkg::REQ_ADD:    tree_add(1, 0, shadow_len - 1, a, b, amt);
            lrt_pkg::REQ_MAX:    ans.range_max = tree_max(1, 0, shadow_len - 1, a, b);
            lrt_pkg::REQ_SEARCH: begin
                ans.found_position = lrt_pkg::POS_W'(leftmost_at_least(amt));
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (answer_q.size() == 0) begin
                $error("unexpected result: range_max %0d found_position %0d",
                       rsp_ch.range_max, rsp_ch.found_position);
                fail_count++;
            end else begin
                exp_ans = answer_q.pop_front();
                if (rsp_ch.range_max !== exp_ans.range_max) begin
                    $error("range_max: expected %0d, actual %0d",
                           $signed(exp_ans.range_max), rsp_ch.range_max);
                    fail_count++;
                end
                if (rsp_ch.found_position !== exp_ans.found_position) begin
                    $error("found_position: expected %0d, actual %0d",
                           exp_ans.found_position, rsp_ch.found_position);
                    fail_count++;
                end
            end
        end
    end

    // Result side ready, with random stalls and one long hold-off.
    always @(posedge i_clk) begin
        if (hold_request && hold_left == 0) begin
            hold_left <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= (hold_left == 1);
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    // Send one request; returns at the edge where it was accepted.
    task automatic send_request(logic [lrt_pkg::TYPE_W-1:0] kind, int a, int b,
                                logic [lrt_pkg::DATA_W-1:0] amt);
        while (!no_idle && $urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.range_low  <= lrt_pkg::POS_W'(a);
        req_ch.range_high <= lrt_pkg::POS_W'(b);
        req_ch.amount     <= amt;
        do @(posedge i_clk); while (!req_ch.ready);
        answer_q.push_back(predict_answer(kind, a & 10'h3FF, b & 10'h3FF, amt));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // APB write while the block is idle.
    task automatic write_register(logic [lrt_pkg::APB_ADDR_W-1:0] addr, logic [31:0] value);
        int unsigned v;
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LENGTH) begin
            v = value & 32'h7FF;
            if (v < 1) v = 1;
            if (v > lrt_pkg::MAX_POSITIONS) v = lrt_pkg::MAX_POSITIONS;
            shadow_len = v;
            clear_shadow();
        end
    endtask

    task automatic test_after_reset();
        send_request(lrt_pkg::REQ_MAX, 0, 1023, 32'd0);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd0);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd1);
        send_request(REQ_UNUSED, 1023, 0, 32'hFFFF_FFFF);
    endtask

    task automatic test_operations();
        send_request(lrt_pkg::REQ_ADD, 0, 0, 32'h7FFF_FFFF);
        send_request(lrt_pkg::REQ_ADD, 1023, 1023, 32'h8000_0000);
        send_request(lrt_pkg::REQ_MAX, 0, 1023, 32'd0);
        send_request(lrt_pkg::REQ_MAX, 1023, 1023, 32'd0);
        // Wrap the largest value past the top.
        send_request(lrt_pkg::REQ_ADD, 0, 1023, 32'd1);
        send_request(lrt_pkg::REQ_MAX, 0, 1023, 32'd0);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'h8000_0000);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'h7FFF_FFFF);
        // Empty range: the add changes nothing, the query sees nothing.
        send_request(lrt_pkg::REQ_ADD, 600, 5, 32'd77);
        send_request(lrt_pkg::REQ_MAX, 600, 5, 32'd0);
        send_request(lrt_pkg::REQ_ADD, 300, 700, 32'd5);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd3);
        send_request(REQ_UNUSED, 0, 1023, 32'd5);
    endtask

    task automatic test_lengths();
        write_register(ADDR_LENGTH, 32'd1);
        send_request(lrt_pkg::REQ_ADD, 0, 1023, 32'd9);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd100);
        send_request(lrt_pkg::REQ_MAX, 1, 1023, 32'd0);
        write_register(ADDR_LENGTH, 32'd0);
        send_request(lrt_pkg::REQ_MAX, 0, 0, 32'd0);
        write_register(ADDR_LENGTH, 32'h7FF);
        send_request(lrt_pkg::REQ_ADD, 1000, 1023, 32'd4);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd4);
        write_register(ADDR_LENGTH, 32'd700);
        // Ranges reaching past the array end are clipped.
        send_request(lrt_pkg::REQ_ADD, 650, 1023, 32'd2);
        send_request(lrt_pkg::REQ_MAX, 700, 1023, 32'd0);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd1);
        send_request(lrt_pkg::REQ_SEARCH, 0, 0, 32'd3);
        write_register(ADDR_NONE, 32'd5);
        send_request(lrt_pkg::REQ_MAX, 0, 699, 32'd0);
    endtask

    task automatic random_request();
        int a, b, pick;
        logic [lrt_pkg::TYPE_W-1:0] kind;
        logic [lrt_pkg::DATA_W-1:0] amt;
        pick = $urandom_range(99);
        kind = pick < 40 ? lrt_pkg::REQ_ADD : pick < 70 ? lrt_pkg::REQ_MAX
             : pick < 95 ? lrt_pkg::REQ_SEARCH : REQ_UNUSED;
        if ($urandom_range(9) < 8) begin
            a = $urandom_range(shadow_len - 1);
            b = $urandom_range(shadow_len - 1, a);
        end else begin
            a = $urandom_range(1023);
            b = $urandom_range(1023);
        end
        amt = ($urandom_range(9) == 0) ? $urandom
            : lrt_pkg::DATA_W'($signed($urandom_range(40)) - 20);
        send_request(kind, a, b, amt);
    endtask

    task automatic test_random();
        int lengths[5] = '{1024, 2, 37, 1024, 500};
        for (int p = 0; p < 5; p++) begin
            write_register(ADDR_LENGTH, lengths[p]);
            no_idle = (p == 3);
            repeat (100) random_request();
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off once the clearing pass is over, so the block fills up.
    task automatic test_backpressure();
        write_register(ADDR_LENGTH, 32'd64);
        no_idle = 1'b1;
        random_request();
        req_ch.valid <= 1'b0;
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        repeat (30) random_request();
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = lrt_pkg::REQ_ADD;
        req_ch.range_low = '0;
        req_ch.range_high = '0;
        req_ch.amount = '0;
        shadow_len = lrt_pkg::MAX_POSITIONS;
        clear_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_operations();
        test_lengths();
        test_random();
        test_backpressure();

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lazy_range_add_max_tree regression: pass");
        end else begin
            $display("lazy_range_add_max_tree regression: fail");
        end
        $finish;
    end

endmodule
